FILE: sv/msc_pkg.sv
// Shared types and constants for the minimum square-sum count unit.
`default_nettype none
package msc_pkg;

	localparam int TGT_W  = 13;
	localparam int CNT_W  = 3;
	localparam int SUM_W  = CNT_W + 1;
	localparam int HALF_W = TGT_W - 1;
	localparam int SQ_W   = TGT_W + 1;
	localparam int ODD_W  = 8;

	localparam logic [CNT_W-1:0] COUNT_CAP  = 3'd5;
	localparam logic [CNT_W-1:0] COUNT_ONE  = 3'd1;
	localparam logic [CNT_W-1:0] COUNT_NONE = 3'd0;
	localparam logic [SUM_W-1:0] EARLY_STOP = 4'd2;

	localparam logic [SQ_W-1:0]  FIRST_SQ  = 14'd1;
	localparam logic [ODD_W-1:0] FIRST_ODD = 8'd3;
	localparam logic [ODD_W-1:0] ODD_STEP  = 8'd2;

	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] count;
	} msc_res_t;

endpackage
`default_nettype wire

FILE: sv/msc_table.sv
// Count table memory: one write port, two registered read ports.
`default_nettype none
module msc_table #(
	parameter int DEPTH = 4097,
	parameter int AW    = 13
) (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire  [AW-1:0]              wr_addr,
	input  wire  [msc_pkg::CNT_W-1:0]  wr_data,
	input  wire  [AW-1:0]              rd_a_addr,
	input  wire  [AW-1:0]              rd_b_addr,
	output logic [msc_pkg::CNT_W-1:0]  rd_a_data,
	output logic [msc_pkg::CNT_W-1:0]  rd_b_data
);

	logic [msc_pkg::CNT_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule
`default_nettype wire

FILE: sv/msc_seq.sv
// Sequencer: walks the table entries and scans splits one per cycle.
`default_nettype none
module msc_seq #(
	parameter int MAX_TARGET = 4096,
	parameter int AW         = 13
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  [msc_pkg::TGT_W-1:0]  target,
	output logic                       idle,
	output msc_pkg::msc_res_t          res,
	input  wire                        res_take,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [msc_pkg::CNT_W-1:0]  wr_data,
	output logic [AW-1:0]              rd_a_addr,
	output logic [AW-1:0]              rd_b_addr,
	input  wire  [msc_pkg::CNT_W-1:0]  rd_a_data,
	input  wire  [msc_pkg::CNT_W-1:0]  rd_b_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                  state_q;
	logic [msc_pkg::TGT_W-1:0]   n_q;
	logic [msc_pkg::TGT_W-1:0]   i_q;
	logic [msc_pkg::SQ_W-1:0]    sq_q;
	logic [msc_pkg::ODD_W-1:0]   odd_q;
	logic [msc_pkg::HALF_W-1:0]  a_q;
	logic [msc_pkg::CNT_W-1:0]   best_q;
	logic [msc_pkg::CNT_W-1:0]   res_q;
	logic                        vld_s1;
	logic                        last_s1;

	logic                        is_square;
	logic                        last_i;
	logic [msc_pkg::SUM_W-1:0]   sum;
	logic [msc_pkg::CNT_W-1:0]   new_best;
	logic                        finish;
	logic                        issue;
	logic                        bad_target;

	assign is_square  = (msc_pkg::SQ_W'(i_q) == sq_q);
	assign last_i     = (i_q == n_q);
	assign sum        = msc_pkg::SUM_W'(rd_a_data) + msc_pkg::SUM_W'(rd_b_data);
	assign new_best   = (sum < msc_pkg::SUM_W'(best_q)) ? sum[msc_pkg::CNT_W-1:0] : best_q;
	assign finish     = (state_q == ST_SCAN) && vld_s1
	                    && ((sum == msc_pkg::EARLY_STOP) || last_s1);
	assign issue      = (state_q == ST_SCAN) && (a_q != '0) && !finish;
	assign bad_target = (target == '0) || (int'(target) > MAX_TARGET);

	assign idle      = (state_q == ST_IDLE);
	assign res.vld   = (state_q == ST_DONE);
	assign res.count = res_q;

	assign rd_a_addr = AW'(a_q);
	assign rd_b_addr = AW'(i_q - msc_pkg::TGT_W'(a_q));
	assign wr_addr   = AW'(i_q);
	assign wr_en     = ((state_q == ST_STEP) && is_square) || finish;
	assign wr_data   = (state_q == ST_STEP) ? msc_pkg::COUNT_ONE : new_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			sq_q    <= msc_pkg::FIRST_SQ;
			odd_q   <= msc_pkg::FIRST_ODD;
		end else begin
			vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (bad_target) begin
							res_q   <= msc_pkg::COUNT_NONE;
							state_q <= ST_DONE;
						end else begin
							n_q     <= target;
							i_q     <= msc_pkg::TGT_W'(1);
							sq_q    <= msc_pkg::FIRST_SQ;
							odd_q   <= msc_pkg::FIRST_ODD;
							state_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					if (is_square) begin
						sq_q  <= sq_q + msc_pkg::SQ_W'(odd_q);
						odd_q <= odd_q + msc_pkg::ODD_STEP;
						if (last_i) begin
							res_q   <= msc_pkg::COUNT_ONE;
							state_q <= ST_DONE;
						end else begin
							i_q <= i_q + msc_pkg::TGT_W'(1);
						end
					end else begin
						a_q     <= i_q[msc_pkg::TGT_W-1:1];
						best_q  <= msc_pkg::COUNT_CAP;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						last_s1 <= (a_q == msc_pkg::HALF_W'(1));
						a_q     <= a_q - msc_pkg::HALF_W'(1);
					end
					if (vld_s1) begin
						best_q <= new_best;
					end
					if (finish) begin
						if (last_i) begin
							res_q   <= new_best;
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_q + msc_pkg::TGT_W'(1);
							state_q <= ST_STEP;
						end
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/min_square_sum_count_unit.sv
// Top level of the minimum square-sum count unit: stream ports and output register.
// For target n the sequencer fills table entries 1 to n in order; each non-square entry scans
// its splits one per cycle, S(n) in total (at most n*n/4).
// Throughput: one item at a time; input is ready only while the sequencer is idle.
// Zero or over-range targets answer 0 without touching the table.
// Reset (arst_n low, asynchronous) clears the sequencer and output valid; table is not cleared.
`default_nettype none
module min_square_sum_count_unit #(
	parameter int MAX_TARGET = 4096
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [15:0] s_axis_tdata,   // [12:0] target
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata    // [2:0] square_count
);

	localparam int DEPTH = MAX_TARGET + 1;
	localparam int AW    = $clog2(DEPTH);

	msc_pkg::msc_res_t           res;
	logic                        idle;
	logic                        res_take;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [msc_pkg::CNT_W-1:0]   wr_data;
	logic [AW-1:0]               rd_a_addr;
	logic [AW-1:0]               rd_b_addr;
	logic [msc_pkg::CNT_W-1:0]   rd_a_data;
	logic [msc_pkg::CNT_W-1:0]   rd_b_data;
	logic                        m_vld_q;
	logic [msc_pkg::CNT_W-1:0]   m_count_q;

	assign s_axis_tready = idle;
	assign res_take      = res.vld && (!m_vld_q || m_axis_tready);
	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {{(8 - msc_pkg::CNT_W){1'b0}}, m_count_q};

	msc_seq #(
		.MAX_TARGET (MAX_TARGET),
		.AW         (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid && s_axis_tready),
		.target    (s_axis_tdata[msc_pkg::TGT_W-1:0]),
		.idle      (idle),
		.res       (res),
		.res_take  (res_take),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	msc_table #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else begin
			if (res_take) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_count_q <= res.count;
		end
	end

endmodule
`default_nettype wire

FILE: sv/msc_checker.sv
// Port-level checks for the minimum square-sum count unit, with bind.
`default_nettype none
module msc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed under stall");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready straight after a transfer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0) && (m_axis_tdata[2:0] <= 3'd4))
		else $error("square count out of range");

endmodule

bind min_square_sum_count_unit msc_checker u_msc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
